// ===== hdl/bytea_text_input_decoder_top_defines.svh =====
// Assertion macros for the bytea text decoder.
// Depends on nothing; included by the modules that check their own logic.
`ifndef BYTEA_TEXT_INPUT_DECODER_TOP_DEFINES_SVH
`define BYTEA_TEXT_INPUT_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BTID_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("btid assertion failed");

// Next-cycle implication, checked outside reset.
`define BTID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("btid assertion failed");

`endif

// ===== hdl/btid_pkg.sv =====
// Shared types and constants for the bytea text decoder.
// Depends on nothing.
package btid_pkg;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_THREE  = 8'h33;
    localparam logic [7:0] CH_SEVEN  = 8'h37;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_HEX    = 2'd1,
        ERR_ODD    = 2'd2,
        ERR_SYNTAX = 2'd3
    } t_err;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic       has_result;
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_string;
        t_err       error_code;
    } t_result;

endpackage

// ===== hdl/btid_in_if.sv =====
// Character channel of the bytea text decoder.
// Depends on nothing.
interface btid_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       last_char;

    modport source (output valid, output char_in, output last_char, input ready);
    modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

// ===== hdl/btid_out_if.sv =====
// Result channel of the bytea text decoder.
// Depends on nothing.
interface btid_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_string;
    logic [1:0] error_code;

    modport source (output valid, output data_byte, output byte_valid,
                    output end_of_string, output error_code, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input end_of_string, input error_code, output ready);
endinterface

// ===== hdl/btid_in_stage.sv =====
// Input register of the bytea text decoder.
// Depends on btid_pkg and btid_in_if.
module btid_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    btid_in_if.sink           i_in,
    input  logic              i_take,
    output logic              o_valid,
    output btid_pkg::t_in_item o_item
);
    import btid_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     accept;

    assign i_in.ready = !r_valid || i_take;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.char_in   <= i_in.char_in;
            r_item.last_char <= i_in.last_char;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

// ===== hdl/btid_core.sv =====
// Parse state and per-character decode of the bytea text decoder.
// Depends on btid_pkg and the assertion macro header.
module btid_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  btid_pkg::t_in_item i_item,
    output btid_pkg::t_result  o_res
);
    import btid_pkg::*;
    `include "bytea_text_input_decoder_top_defines.svh"

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_PFX_BS = 3'd1,
        PH_HEX_A  = 3'd2,
        PH_HEX_B  = 3'd3,
        PH_PLAIN  = 3'd4,
        PH_ESC_BS = 3'd5,
        PH_OCT_1  = 3'd6,
        PH_OCT_2  = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        K_HOLD,
        K_GIVE,
        K_QUIET,
        K_FAIL
    } t_kind;

    t_phase     r_phase, n_phase;
    logic [7:0] r_held,  n_held;
    logic       r_drain, n_drain;

    t_kind      kind;
    t_phase     nxt;
    logic [7:0] held_nxt;
    logic [7:0] give_byte;
    t_err       fail_err;

    logic [7:0] c;
    logic       last;
    logic       is_space, is_oct, is_low_oct, hex_ok;
    logic [3:0] hex_v;

    assign c    = i_item.char_in;
    assign last = i_item.last_char;

    assign is_space   = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
    assign is_oct     = (c >= CH_ZERO) && (c <= CH_SEVEN);
    assign is_low_oct = (c >= CH_ZERO) && (c <= CH_THREE);

    always_comb begin
        hex_ok = 1'b1;
        hex_v  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            hex_v = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            hex_v = c[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        kind      = K_HOLD;
        nxt       = r_phase;
        held_nxt  = r_held;
        give_byte = 8'd0;
        fail_err  = ERR_NONE;
        case (r_phase)
            PH_PFX_BS, PH_ESC_BS: begin
                if (r_phase == PH_PFX_BS && c == CH_X) begin
                    kind = K_QUIET;
                    nxt  = PH_HEX_A;
                end else if (c == CH_BSLASH) begin
                    kind      = K_GIVE;
                    give_byte = CH_BSLASH;
                    nxt       = PH_PLAIN;
                end else if (is_low_oct && !last) begin
                    held_nxt = {c[1:0], 6'd0};
                    nxt      = PH_OCT_1;
                end else begin
                    kind     = K_FAIL;
                    fail_err = ERR_SYNTAX;
                end
            end
            PH_HEX_A: begin
                if (is_space) begin
                    kind = K_QUIET;
                    nxt  = PH_HEX_A;
                end else if (!hex_ok) begin
                    kind     = K_FAIL;
                    fail_err = ERR_HEX;
                end else if (last) begin
                    kind     = K_FAIL;
                    fail_err = ERR_ODD;
                end else begin
                    held_nxt = {hex_v, 4'd0};
                    nxt      = PH_HEX_B;
                end
            end
            PH_HEX_B: begin
                if (!hex_ok) begin
                    kind     = K_FAIL;
                    fail_err = ERR_HEX;
                end else begin
                    kind      = K_GIVE;
                    give_byte = r_held | {4'd0, hex_v};
                    nxt       = PH_HEX_A;
                end
            end
            PH_PLAIN: begin
                if (c == CH_BSLASH) begin
                    if (last) begin
                        kind     = K_FAIL;
                        fail_err = ERR_SYNTAX;
                    end else begin
                        nxt = PH_ESC_BS;
                    end
                end else begin
                    kind      = K_GIVE;
                    give_byte = c;
                    nxt       = PH_PLAIN;
                end
            end
            PH_OCT_1: begin
                if (!is_oct || last) begin
                    kind     = K_FAIL;
                    fail_err = ERR_SYNTAX;
                end else begin
                    held_nxt = r_held | {2'd0, c[2:0], 3'd0};
                    nxt      = PH_OCT_2;
                end
            end
            PH_OCT_2: begin
                if (!is_oct) begin
                    kind     = K_FAIL;
                    fail_err = ERR_SYNTAX;
                end else begin
                    kind      = K_GIVE;
                    give_byte = r_held | {5'd0, c[2:0]};
                    nxt       = PH_PLAIN;
                end
            end
            default: begin
                if (c == CH_BSLASH) begin
                    if (last) begin
                        kind     = K_FAIL;
                        fail_err = ERR_SYNTAX;
                    end else begin
                        nxt = PH_PFX_BS;
                    end
                end else begin
                    kind      = K_GIVE;
                    give_byte = c;
                    nxt       = PH_PLAIN;
                end
            end
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        n_drain = r_drain;
        o_res   = '{has_result: 1'b0, data_byte: 8'd0, byte_valid: 1'b0,
                    end_of_string: 1'b0, error_code: ERR_NONE};
        if (r_drain) begin
            if (last) begin
                n_drain = 1'b0;
                n_phase = PH_START;
                n_held  = 8'd0;
            end
        end else begin
            case (kind)
                K_HOLD: begin
                    n_phase = nxt;
                    n_held  = held_nxt;
                end
                K_GIVE: begin
                    o_res.has_result    = 1'b1;
                    o_res.data_byte     = give_byte;
                    o_res.byte_valid    = 1'b1;
                    o_res.end_of_string = last;
                    if (last) begin
                        n_phase = PH_START;
                        n_held  = 8'd0;
                    end else begin
                        n_phase = nxt;
                    end
                end
                K_QUIET: begin
                    if (last) begin
                        o_res.has_result    = 1'b1;
                        o_res.end_of_string = 1'b1;
                        n_phase             = PH_START;
                        n_held              = 8'd0;
                    end else begin
                        n_phase = nxt;
                    end
                end
                K_FAIL: begin
                    o_res.has_result    = 1'b1;
                    o_res.end_of_string = 1'b1;
                    o_res.error_code    = fail_err;
                    n_phase             = PH_START;
                    n_held              = 8'd0;
                    n_drain             = !last;
                end
                default: begin
                    n_phase = PH_START;
                    n_held  = 8'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_held  <= 8'd0;
            r_drain <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_drain <= n_drain;
        end
    end

    `BTID_ASSERT_NOW(a_drain_silent, i_clk, i_rst_n, i_fire && r_drain, !o_res.has_result)
    `BTID_ASSERT_NEXT(a_err_starts_drain, i_clk, i_rst_n,
        i_fire && o_res.error_code != ERR_NONE && !last, r_drain)
    `BTID_ASSERT_NEXT(a_last_restarts, i_clk, i_rst_n,
        i_fire && last, r_phase == PH_START && !r_drain)
endmodule

// ===== hdl/btid_out_stage.sv =====
// Result register of the bytea text decoder.
// Depends on btid_pkg and btid_out_if.
module btid_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  btid_pkg::t_result i_res,
    output logic              o_free,
    btid_out_if.source        o_out
);
    import btid_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.data_byte     = r_res.data_byte;
    assign o_out.byte_valid    = r_res.byte_valid;
    assign o_out.end_of_string = r_res.end_of_string;
    assign o_out.error_code    = r_res.error_code;
endmodule

// ===== hdl/bytea_text_input_decoder_top.sv =====
// Channel     | Dir | Payload                                              | Transaction
// i_in        | in  | char_in[7:0], last_char                              | valid & ready
// o_out       | out | data_byte[7:0], byte_valid, end_of_string, err[1:0] | valid & ready
//
// One character per cycle while no result is stalled. A character is registered in the
// input register and its result in the result register; the path between them, through
// the parse-state update, sets the rate. Reset is synchronous, active low, and returns
// to the start of a string. A stalled result blocks only a character that would produce
// a result. Top level of the bytea text decoder. Depends on btid_pkg, btid_in_if,
// btid_out_if, btid_in_stage, btid_core, btid_out_stage and the assertion macro header.
module bytea_text_input_decoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    btid_in_if.sink    i_in,
    btid_out_if.source o_out
);
    import btid_pkg::*;
    `include "bytea_text_input_decoder_top_defines.svh"

    logic     stage_valid;
    t_in_item stage_item;
    t_result  res;
    logic     out_free;
    logic     take;

    assign take = stage_valid && (!res.has_result || out_free);

    btid_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    btid_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (take),
        .i_item  (stage_item),
        .o_res   (res)
    );

    btid_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take && res.has_result),
        .i_res   (res),
        .o_free  (out_free),
        .o_out   (o_out)
    );

    `BTID_ASSERT_NOW(a_err_closes, i_clk, i_rst_n,
        o_out.valid && o_out.error_code != ERR_NONE, o_out.end_of_string && !o_out.byte_valid)
    `BTID_ASSERT_NOW(a_byte_no_err, i_clk, i_rst_n,
        o_out.valid && o_out.byte_valid, o_out.error_code == ERR_NONE)
    `BTID_ASSERT_NOW(a_stall_blocks, i_clk, i_rst_n,
        stage_valid && res.has_result && o_out.valid && !o_out.ready, !i_in.ready)
endmodule
